// ===== rtl/mfau_pkg.sv =====
// Shared types and constants for the motor feedback angle unwrap block.
// Used by the top level, the unwrap stage and the port checker.
`default_nettype none

package mfau_pkg;

  // Fixed field widths of the feedback frame and the result item
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RAW_W   = 16;  // raw rotor angle, speed, current
  localparam int unsigned TURN_W  = 16;  // reported turn count
  localparam int unsigned ANGLE_W = 13;  // 8192 counts per revolution
  localparam int unsigned RATIO_W = 24;  // gear ratio, unsigned Q8.16
  localparam int unsigned FRAC_W  = 16;
  // Only product bits up to FRAC_W+ANGLE_W-1 are reported, so the position
  // and the product are carried modulo 2^POS_W.
  localparam int unsigned POS_W   = FRAC_W + ANGLE_W;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 24'h01_0000;  // 1.0

  // Input item, first byte in the lowest bits
  typedef struct packed {
    logic [BYTE_W-1:0] b6;
    logic [BYTE_W-1:0] b5;
    logic [BYTE_W-1:0] b4;
    logic [BYTE_W-1:0] b3;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b0;
  } in_item_t;

  // Result item, shaft_speed in the lowest bits, zero pad on top
  typedef struct packed {
    logic [2:0]         pad;
    logic [TURN_W-1:0]  turn_total;
    logic [ANGLE_W-1:0] output_angle;
    logic [BYTE_W-1:0]  motor_temp;
    logic [RAW_W-1:0]   shaft_current;
    logic [RAW_W-1:0]   shaft_speed;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/mfau_unwrap.sv =====
// Rotor wrap detector and turn counter; holds previous angle and turn count.
// Depends on mfau_pkg for field widths.
`default_nettype none

module mfau_unwrap #(
  parameter int unsigned TURN_BITS  = 16,
  parameter int unsigned WRAP_GUARD = 1000
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,       // item leaves the input stage
  input  wire logic [mfau_pkg::RAW_W-1:0]   angle,
  input  wire logic                         speed_neg,
  output logic      [mfau_pkg::TURN_W-1:0]  turn_total,
  output logic      [mfau_pkg::POS_W-1:0]   position
);
  import mfau_pkg::*;

  localparam logic [RAW_W:0] GUARD = (RAW_W+1)'(WRAP_GUARD);

  logic        [RAW_W-1:0]     prev_angle_r;
  logic signed [TURN_BITS-1:0] turn_r;
  logic signed [TURN_BITS-1:0] turn_nxt;
  logic        [RAW_W:0]       angle_ext;
  logic        [RAW_W:0]       prev_ext;
  logic                        fwd_wrap;
  logic                        rev_wrap;

  // Compare against the old angle with the guard band, no sign issues in 17 bits
  assign angle_ext = {1'b0, angle};
  assign prev_ext  = {1'b0, prev_angle_r};
  assign fwd_wrap  = !speed_neg && ((angle_ext + GUARD) < prev_ext);
  assign rev_wrap  =  speed_neg && (angle_ext > (prev_ext + GUARD));

  // Advance the count, wrapping at its width
  always_comb begin
    turn_nxt = turn_r;
    if (fwd_wrap) begin
      turn_nxt = turn_r + TURN_BITS'(1);
    end else if (rev_wrap) begin
      turn_nxt = turn_r - TURN_BITS'(1);
    end
  end

  // Sign-extend or truncate to the reported width; position = turns*8192 + angle
  assign turn_total = TURN_W'(turn_nxt);
  assign position   = {turn_total, {ANGLE_W{1'b0}}} + POS_W'(angle);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= '0;
      turn_r       <= '0;
    end else if (step) begin
      prev_angle_r <= angle;
      turn_r       <= turn_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/motor_feedback_angle_unwrap_core.sv =====
// Motor feedback decoder: frame unpack, multi-turn unwrap, gear-ratio scaling.
// Depends on mfau_pkg and mfau_unwrap.
//
//  channel  | direction | fields (tdata, lowest bit first)
//  ---------+-----------+-----------------------------------------------------
//  in_      | slave     | payload_b0 .. payload_b6, 8 bits each (56 bits)
//  out_     | master    | shaft_speed 16, shaft_current 16, motor_temp 8,
//           |           | output_angle 13, turn_total 16, 3 zero bits (72)
//  cfg_     | write     | gear_ratio_q8_16, 24 bits
//
// Three register stages: input, unwrap/position, result (gear multiply). One
// item per cycle sustained while out_tready is high; an accepted item passes
// the unwrap/position and result registers before out_tvalid rises. The turn
// count advances as an item leaves the input stage. in_tready drops only when
// all three stages are full and out_tready is low. Synchronous active-low
// reset empties the pipe, clears the state and sets the gear ratio to 1.0.
`default_nettype none

module motor_feedback_angle_unwrap_core #(
  parameter int unsigned TURN_BITS  = 16,
  parameter int unsigned WRAP_GUARD = 1000
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // payload_b0 [7:0], b1 [15:8], b2 [23:16], b3 [31:24], b4 [39:32],
  // b5 [47:40], b6 [55:48]
  input  wire logic [mfau_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // shaft_speed [15:0], shaft_current [31:16], motor_temp [39:32],
  // output_angle [52:40], turn_total [68:53], zero [71:69]
  output logic      [mfau_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_we,
  input  wire logic [mfau_pkg::RATIO_W-1:0]       cfg_wdata
);
  import mfau_pkg::*;

  logic [RATIO_W-1:0] ratio_r;

  // Stage 1: input register
  in_item_t           s1_r;
  logic               s1_vld_r;

  // Stage 2: position and pass-through fields
  logic               s2_vld_r;
  logic [POS_W-1:0]   s2_pos_r;
  logic [TURN_W-1:0]  s2_turn_r;
  logic [RAW_W-1:0]   s2_speed_r;
  logic [RAW_W-1:0]   s2_current_r;
  logic [BYTE_W-1:0]  s2_temp_r;

  // Stage 3: result register
  out_item_t          out_r;
  logic               out_vld_r;

  logic               adv_out;
  logic               adv_s2;
  logic               adv_s1;
  logic [RAW_W-1:0]   s1_angle;
  logic [RAW_W-1:0]   s1_speed;
  logic [TURN_W-1:0]  uw_turn;
  logic [POS_W-1:0]   uw_pos;
  logic [POS_W-1:0]   product;

  // Stage enables: move when the next stage is empty or moving
  assign adv_out   = !out_vld_r || out_tready;
  assign adv_s2    = !s2_vld_r || adv_out;
  assign adv_s1    = !s1_vld_r || adv_s2;
  assign in_tready = adv_s1;

  // Unpack big-endian fields
  assign s1_angle = {s1_r.b0, s1_r.b1};
  assign s1_speed = {s1_r.b2, s1_r.b3};

  mfau_unwrap #(
    .TURN_BITS  (TURN_BITS),
    .WRAP_GUARD (WRAP_GUARD)
  ) u_unwrap (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_vld_r && adv_s2),
    .angle      (s1_angle),
    .speed_neg  (s1_speed[RAW_W-1]),
    .turn_total (uw_turn),
    .position   (uw_pos)
  );

  // Scale by the gear ratio; keep only the bits that reach the result
  assign product = s2_pos_r * POS_W'(ratio_r);

  // Gear ratio register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
    end else if (cfg_we) begin
      ratio_r <= cfg_wdata;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_vld_r <= in_tvalid;
      end
      if (adv_s2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (adv_out) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv_s1) begin
      s1_r <= in_item_t'(in_tdata);
    end
    if (adv_s2) begin
      s2_pos_r     <= uw_pos;
      s2_turn_r    <= uw_turn;
      s2_speed_r   <= s1_speed;
      s2_current_r <= {s1_r.b4, s1_r.b5};
      s2_temp_r    <= s1_r.b6;
    end
    if (adv_out) begin
      out_r.pad           <= '0;
      out_r.turn_total    <= s2_turn_r;
      out_r.output_angle  <= product[POS_W-1:FRAC_W];
      out_r.motor_temp    <= s2_temp_r;
      out_r.shaft_current <= s2_current_r;
      out_r.shaft_speed   <= s2_speed_r;
    end
  end

  assign out_tdata  = out_r;
  assign out_tvalid = out_vld_r;

endmodule

`default_nettype wire

// ===== rtl/mfau_checker.sv =====
// Port-level checker for the angle unwrap core, bound to the top level.
// Depends on mfau_pkg for result field widths.
`default_nettype none

module mfau_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tready,
  input  wire logic [mfau_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire logic                               out_tvalid,
  input  wire logic                               out_tready
);
  import mfau_pkg::*;

  out_item_t         res;
  logic [TURN_W-1:0] last_turn_r;
  logic              seen_r;
  logic              out_fire;
  logic              turn_up;
  logic              turn_down;

  assign res       = out_item_t'(out_tdata);
  assign out_fire  = out_tvalid && out_tready;
  assign turn_up   = res.turn_total == (last_turn_r + TURN_W'(1));
  assign turn_down = res.turn_total == (last_turn_r - TURN_W'(1));

  // Track the turn count of the last delivered item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_fire) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      last_turn_r <= res.turn_total;
    end
  end

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Empty result stage never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low while result stage empty");

  // Turn count moves by at most one between delivered items
  a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && seen_r) |->
      (res.turn_total == last_turn_r) || turn_up || turn_down)
    else $error("turn_total jumped by more than one");

  // A forward turn needs non-negative speed, a reverse turn negative speed
  a_turn_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && seen_r && (turn_up || turn_down)) |->
      (turn_up && !res.shaft_speed[RAW_W-1]) ||
      (turn_down && res.shaft_speed[RAW_W-1]))
    else $error("turn direction disagrees with speed sign");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result item changed");

endmodule

bind motor_feedback_angle_unwrap_core mfau_checker u_mfau_checker (.*);

`default_nettype wire

// ===== tb/sv/mfau_result_check.sv =====
// Result checker for motor_feedback_angle_unwrap_core: watches the frame, result and
// gear ratio ports, predicts every result item and compares it field by field.
// Depends on mfau_pkg for the item layouts and field widths.
`timescale 1ns / 1ps

module mfau_result_check #(
  parameter int unsigned TURN_BITS  = 16,
  parameter int unsigned WRAP_GUARD = 1000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mfau_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [mfau_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [mfau_pkg::RATIO_W-1:0]        cfg_wdata,
  output int                                  fail_count,
  output int                                  pending
);
  import mfau_pkg::*;

  localparam int REV_COUNTS  = 1 << ANGLE_W;

  out_item_t              expected_results[$];
  logic [RATIO_W-1:0]     gear_ratio;
  logic [RAW_W-1:0]       last_angle;
  logic [TURN_BITS-1:0]   turn_count;

  // Advance the unwrap state by one frame and return the result it should give
  function automatic out_item_t unwrap_frame(in_item_t frame);
    logic [RAW_W-1:0] angle;
    logic [RAW_W-1:0] speed;
    int               now_angle;
    int               prev_angle;
    longint           position;
    longint           scaled;
    out_item_t        res;
    angle      = {frame.b0, frame.b1};
    speed      = {frame.b2, frame.b3};
    now_angle  = int'(angle);
    prev_angle = int'(last_angle);
    // Forward wrap counts up, reverse wrap counts down, both modulo the count width
    if (!speed[RAW_W-1]) begin
      if (now_angle < prev_angle - int'(WRAP_GUARD)) turn_count = turn_count + 1'b1;
    end else begin
      if (now_angle > prev_angle + int'(WRAP_GUARD)) turn_count = turn_count - 1'b1;
    end
    position   = longint'($signed(turn_count)) * REV_COUNTS + longint'(angle);
    scaled     = position * longint'(gear_ratio);
    last_angle = angle;
    res               = '0;
    res.shaft_speed   = speed;
    res.shaft_current = {frame.b4, frame.b5};
    res.motor_temp    = frame.b6;
    res.output_angle  = scaled[FRAC_W +: ANGLE_W];
    res.turn_total    = TURN_W'($signed(turn_count));
    return res;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Track the register, pop one expectation per result and push one per frame
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      gear_ratio = RATIO_RESET;
      last_angle = '0;
      turn_count = '0;
      fail_count = 0;
    end else begin
      if (cfg_we) gear_ratio = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
        end else begin
          out_item_t want;
          out_item_t got;
          want = expected_results.pop_front();
          got  = out_tdata;
          compare_field("shaft_speed", want.shaft_speed, got.shaft_speed);
          compare_field("shaft_current", want.shaft_current, got.shaft_current);
          compare_field("motor_temp", want.motor_temp, got.motor_temp);
          compare_field("output_angle", want.output_angle, got.output_angle);
          compare_field("turn_total", want.turn_total, got.turn_total);
          compare_field("pad", want.pad, got.pad);
        end
      end
      if (in_tvalid && in_tready) expected_results.push_back(unwrap_frame(in_tdata));
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the motor_feedback_angle_unwrap_core regression: clock, reset, frame and
// gear ratio stimulus, random back-pressure and the verdict.
// Depends on mfau_pkg, the block itself and mfau_result_check.
`timescale 1ns / 1ps

module tb_top;
  import mfau_pkg::*;

  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_GAP         = 19;
  localparam int LONG_HOLD       = 80;
  localparam int PHASE_COUNT     = 10;
  localparam int PHASE_FRAMES    = 110;
  // Forward wraps in a row at full rate
  localparam int SWEEP_WRAPS     = 40;
  localparam int WRAP_DROP_MIN   = 1001;
  localparam int WRAP_DROP_MAX   = 1100;
  localparam int SMOOTH_STEP_MAX = 1500;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [RATIO_W-1:0]     cfg_wdata;

  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          tx_gaps;
  bit          rx_gaps;
  int          rx_hold;
  logic [15:0] last_sent_angle;

  motor_feedback_angle_unwrap_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mfau_result_check result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort when neither channel moves an item for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("motor_feedback_angle_unwrap_core regression: fail");
      $finish;
    end
  end

  function automatic in_item_t frame_of(logic [15:0] angle, logic [15:0] speed,
                                        logic [15:0] current, logic [7:0] temp);
    in_item_t f;
    f.b0 = angle[15:8];
    f.b1 = angle[7:0];
    f.b2 = speed[15:8];
    f.b3 = speed[7:0];
    f.b4 = current[15:8];
    f.b5 = current[7:0];
    f.b6 = temp;
    return f;
  endfunction

  // Mostly smooth rotor motion that wraps over 8191/0, with raw noise frames mixed in
  function automatic in_item_t next_random_frame();
    logic [15:0] angle;
    logic [15:0] speed;
    logic [15:0] step;
    if ($urandom_range(0, 9) < 3)
      return in_item_t'(IN_TDATA_W'({$urandom(), $urandom()}));
    step = 16'($urandom_range(0, SMOOTH_STEP_MAX));
    if ($urandom_range(0, 1) == 1) begin
      speed = 16'h8000 | 16'($urandom());
      angle = (last_sent_angle - step) & 16'h1FFF;
    end else begin
      speed = 16'($urandom_range(0, 16'h7FFF));
      angle = (last_sent_angle + step) & 16'h1FFF;
    end
    return frame_of(angle, speed, 16'($urandom()), 8'($urandom()));
  endfunction

  // Offer one frame after an optional gap and hold it until accepted
  task automatic send_frame(in_item_t frame);
    int gap;
    gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = frame;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    last_sent_angle = {frame.b0, frame.b1};
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_ratio(logic [RATIO_W-1:0] ratio);
    wait_drained();
    cfg_wdata = ratio;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Drive the turn count up by repeated forward wraps, refilling the angle when low
  task automatic sweep_turns();
    logic [15:0] angle;
    int          wraps;
    angle = 16'hFFFF;
    wraps = 0;
    send_frame(frame_of(angle, 16'h0000, 16'($urandom()), 8'($urandom())));
    while (wraps < SWEEP_WRAPS) begin
      if (angle < WRAP_DROP_MAX + 1) begin
        angle = 16'hFFFF;
      end else begin
        angle = angle - 16'($urandom_range(WRAP_DROP_MIN, WRAP_DROP_MAX));
        wraps++;
      end
      send_frame(frame_of(angle, 16'($urandom_range(0, 16'h7FFF)), 16'($urandom()),
                          8'($urandom())));
    end
  endtask

  // Receiver: random gaps per item, plus one long hold-off on request
  initial begin
    int gap;
    int hold;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold != 0) begin
        hold       = rx_hold;
        rx_hold    = 0;
        out_tready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      gap = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [RATIO_W-1:0] ratio;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    tx_gaps         = 1'b0;
    rx_gaps         = 1'b0;
    rx_hold         = 0;
    last_sent_angle = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Forward wraps back-to-back
    write_ratio(RATIO_W'($urandom()));
    sweep_turns();

    // Directed frames: reverse wraps, guard boundaries both ways, raw angles
    // above one revolution and the extremes of every byte
    write_ratio(24'h01_8000);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_frame(frame_of(16'd0,     16'h8000, 16'h7FFF, 8'hFF));
    send_frame(frame_of(16'd1001,  16'hFFFF, 16'h8000, 8'h00));
    send_frame(frame_of(16'd2001,  16'hC000, 16'h0000, 8'h01));
    send_frame(frame_of(16'd3002,  16'h8001, 16'hFFFF, 8'h80));
    send_frame(frame_of(16'd4003,  16'hFFFF, 16'h0001, 8'h7F));
    send_frame(frame_of(16'd3003,  16'h0000, 16'h1234, 8'h10));
    send_frame(frame_of(16'd2002,  16'h7FFF, 16'h8000, 8'hFE));
    send_frame(frame_of(16'hFFFF,  16'h0001, 16'h8000, 8'h00));
    send_frame(frame_of(16'h2000,  16'h0000, 16'h7FFF, 8'h01));
    send_frame(frame_of(16'h1FFF,  16'hFFFF, 16'h0000, 8'hFF));
    send_frame(frame_of(16'hFFFF,  16'hFFFF, 16'hFFFF, 8'hFF));
    send_frame(frame_of(16'hAAAA,  16'h5555, 16'hAAAA, 8'h55));
    send_frame(frame_of(16'h5555,  16'h2AAA, 16'h5555, 8'hAA));
    send_frame(frame_of(16'h0000,  16'h0000, 16'h0000, 8'h00));

    // Random phases, each with its own gear ratio and idling pattern
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       ratio = '0;
        1:       ratio = '1;
        2:       ratio = RATIO_RESET;
        3:       ratio = 24'h00_0001;
        default: ratio = RATIO_W'($urandom());
      endcase
      write_ratio(ratio);
      tx_gaps = (phase % 3 != 0) && (phase != 2);
      rx_gaps = (phase % 4 != 1);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        // Stall the receiver long enough to fill the pipe and stall the input
        if (phase == 2 && n == 10) rx_hold = LONG_HOLD;
        send_frame(next_random_frame());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("motor_feedback_angle_unwrap_core regression: pass");
    end else begin
      $display("motor_feedback_angle_unwrap_core regression: fail");
    end
    $finish;
  end

endmodule
